### hw/rtl/imu_pkg.sv
`default_nettype none

package imu_pkg;

    localparam int DataW     = 64;
    localparam int DivStages = DataW;  // one quotient bit per stage
    localparam int EtypeW    = 3;
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = EtypeW;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_ELEMENT_TYPE   = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_TRUNCATED_MODE = 1'd1;

    localparam logic [EtypeW-1:0] ETYPE_RESET = 3'd6;

    // element size codes, low two bits of element_type
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    typedef struct packed {
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic [DataW-1:0] remainder;
        logic             divide_by_zero;
    } rsp_t;

    // operands after width selection and extension
    typedef struct packed {
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic             a_neg;
        logic             b_neg;
        logic             dz;
        logic             trunc;
    } ext_t;

    // one restoring-division stage
    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DataW-1:0] a_sh;
        logic [DataW-1:0] b_mag;
        logic             a_neg;
        logic             b_neg;
        logic             dz;
        logic             trunc;
    } div_t;

endpackage

`default_nettype wire

### hw/rtl/integer_modulo_unit_top.sv
// Channel  Signals                         Word
// -------  ------------------------------  -------------------------------
// req      req_valid, req_stall, req_data  dividend, divisor (req_t)
// rsp      rsp_valid, rsp_stall, rsp_data  remainder, divide_by_zero (rsp_t)
// cfg      cfg_write, cfg_index, cfg_data  element_type, truncated_mode
//
// One word enters per cycle while the pipeline is not stalled; the stages are
// operand extension, magnitude, 64 restoring-division stages (one dividend
// bit each), and sign fixup into the output register.
// Reset clears the valid bits and loads element_type = 6, truncated_mode = 0.
// Each stage moves when the one after it is empty or moving, so bubbles
// close up under rsp_stall and nothing is lost or repeated.
`default_nettype none

module integer_modulo_unit_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output      logic                          req_stall,
    input  wire imu_pkg::req_t                 req_data,
    output      logic                          rsp_valid,
    input  wire logic                          rsp_stall,
    output      imu_pkg::rsp_t                 rsp_data,
    input  wire logic                          cfg_write,
    input  wire logic [imu_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [imu_pkg::CfgDataW-1:0]  cfg_data
);
    import imu_pkg::*;

    localparam int Last = DivStages;

    logic [EtypeW-1:0] etype_reg;
    logic              trunc_reg;

    ext_t              ext_next;
    ext_t              ext_reg;
    logic              ext_v_reg;
    logic              ext_rdy;

    div_t              div_reg   [0:Last];
    logic              div_v_reg [0:Last];
    logic [Last+1:0]   div_rdy;

    rsp_t              rsp_next;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    logic              out_rdy;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            etype_reg <= ETYPE_RESET;
            trunc_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ELEMENT_TYPE:   etype_reg <= cfg_data;
                REG_TRUNCATED_MODE: trunc_reg <= cfg_data[0];
            endcase
        end
    end

    // backpressure chain: a stage loads when empty or when its successor loads
    assign out_rdy        = !rsp_valid_reg || !rsp_stall;
    assign div_rdy[Last+1] = out_rdy;
    assign ext_rdy        = !ext_v_reg || div_rdy[0];
    assign req_stall      = !ext_rdy;

    // stage: width select and extension
    always_comb
    begin
        logic sgn;
        sgn = etype_reg[2];
        case (etype_reg[1:0])
            SIZE_8:
            begin
                ext_next.a = {{(DataW-8){sgn & req_data.dividend[7]}}, req_data.dividend[7:0]};
                ext_next.b = {{(DataW-8){sgn & req_data.divisor[7]}}, req_data.divisor[7:0]};
            end
            SIZE_16:
            begin
                ext_next.a = {{(DataW-16){sgn & req_data.dividend[15]}},
                              req_data.dividend[15:0]};
                ext_next.b = {{(DataW-16){sgn & req_data.divisor[15]}},
                              req_data.divisor[15:0]};
            end
            SIZE_32:
            begin
                ext_next.a = {{(DataW-32){sgn & req_data.dividend[31]}},
                              req_data.dividend[31:0]};
                ext_next.b = {{(DataW-32){sgn & req_data.divisor[31]}},
                              req_data.divisor[31:0]};
            end
            default:
            begin
                ext_next.a = req_data.dividend;
                ext_next.b = req_data.divisor;
            end
        endcase
        ext_next.a_neg = sgn & ext_next.a[DataW-1];
        ext_next.b_neg = sgn & ext_next.b[DataW-1];
        ext_next.dz    = (ext_next.b == '0);
        ext_next.trunc = trunc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ext_v_reg <= 1'b0;
        else if (ext_rdy)
            ext_v_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ext_rdy && req_valid)
            ext_reg <= ext_next;
    end

    // stage 0 of div_reg: magnitudes
    assign div_rdy[0] = !div_v_reg[0] || div_rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_v_reg[0] <= 1'b0;
        else if (div_rdy[0])
            div_v_reg[0] <= ext_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (div_rdy[0] && ext_v_reg)
        begin
            div_reg[0].rem   <= '0;
            div_reg[0].a_sh  <= ext_reg.a_neg ? (DataW)'(0) - ext_reg.a : ext_reg.a;
            div_reg[0].b_mag <= ext_reg.b_neg ? (DataW)'(0) - ext_reg.b : ext_reg.b;
            div_reg[0].a_neg <= ext_reg.a_neg;
            div_reg[0].b_neg <= ext_reg.b_neg;
            div_reg[0].dz    <= ext_reg.dz;
            div_reg[0].trunc <= ext_reg.trunc;
        end
    end

    // restoring division, one dividend bit per stage, MSB first
    for (genvar k = 1; k <= Last; k++)
    begin : g_div
        logic [DataW:0] shifted;
        logic [DataW:0] diff;
        div_t           stage_next;

        assign div_rdy[k] = !div_v_reg[k] || div_rdy[k+1];

        always_comb
        begin
            shifted    = {div_reg[k-1].rem, div_reg[k-1].a_sh[DataW-1]};
            diff       = shifted - {1'b0, div_reg[k-1].b_mag};
            stage_next = div_reg[k-1];
            stage_next.rem  = diff[DataW] ? shifted[DataW-1:0] : diff[DataW-1:0];
            stage_next.a_sh = div_reg[k-1].a_sh << 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v_reg[k] <= 1'b0;
            else if (div_rdy[k])
                div_v_reg[k] <= div_v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (div_rdy[k] && div_v_reg[k-1])
                div_reg[k] <= stage_next;
        end
    end

    // sign fixup; with a zero divisor this yields the extended dividend
    always_comb
    begin
        div_t             d;
        logic             fix;
        logic [DataW-1:0] lhs;
        logic [DataW-1:0] rhs;
        d   = div_reg[Last];
        fix = !d.trunc && (d.rem != '0) && (d.a_neg != d.b_neg);
        if (fix)
        begin
            lhs = d.b_neg ? d.rem   : d.b_mag;
            rhs = d.b_neg ? d.b_mag : d.rem;
        end
        else
        begin
            lhs = d.a_neg ? '0    : d.rem;
            rhs = d.a_neg ? d.rem : '0;
        end
        rsp_next.remainder      = lhs - rhs;
        rsp_next.divide_by_zero = d.dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_rdy)
            rsp_valid_reg <= div_v_reg[Last];
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_v_reg[Last])
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // a free output must open the whole chain
    a_chain_open: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_stall |-> !req_stall)
        else $error("input stalled while output is free");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_v_reg[Last] && div_reg[Last].b_mag != '0
            |-> div_reg[Last].rem < div_reg[Last].b_mag)
        else $error("partial remainder not below divisor");

    a_dz_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_v_reg[Last] |-> (div_reg[Last].dz == (div_reg[Last].b_mag == '0)))
        else $error("zero-divisor flag disagrees with divisor magnitude");

    a_out_moves: assert property (@(posedge clk) disable iff (!rst_n)
        div_v_reg[Last] && out_rdy |=> rsp_valid)
        else $error("finished word did not reach output");

endmodule

`default_nettype wire
